// ===== hdl/whp_pkg.sv =====
// Shared types and constants for the WAV header parser.
// Holds the parse phase encoding, the parser state and result records,
// and the chunk signatures. No dependencies.
package whp_pkg;

  typedef enum logic [15:0] {
    PH_IDLE  = 16'h0001,
    PH_RIFF  = 16'h0002,
    PH_RSIZE = 16'h0004,
    PH_WAVE  = 16'h0008,
    PH_FMT   = 16'h0010,
    PH_FSIZE = 16'h0020,
    PH_AFMT  = 16'h0040,
    PH_CHAN  = 16'h0080,
    PH_RATE  = 16'h0100,
    PH_SKIP6 = 16'h0200,
    PH_BITS  = 16'h0400,
    PH_CID   = 16'h0800,
    PH_CSIZE = 16'h1000,
    PH_CSKIP = 16'h2000,
    PH_DSIZE = 16'h4000,
    PH_DATA  = 16'h8000
  } whp_phase_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_RIFF  = 3'd1;
  localparam logic [2:0] ST_NO_WAVE  = 3'd2;
  localparam logic [2:0] ST_NO_FMT   = 3'd3;
  localparam logic [2:0] ST_NOT_PCM  = 3'd4;
  localparam logic [2:0] ST_BAD_CHAN = 3'd5;

  // Signatures as they appear in the shift register once four bytes are in.
  localparam logic [31:0] SIG_RIFF = 32'h4646_4952;
  localparam logic [31:0] SIG_WAVE = 32'h4556_4157;
  localparam logic [31:0] SIG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] SIG_DATA = 32'h6174_6164;

  localparam logic [15:0] PCM_FORMAT   = 16'd1;
  localparam logic [15:0] CHANS_MONO   = 16'd1;
  localparam logic [15:0] CHANS_STEREO = 16'd2;
  localparam logic [15:0] BITS_EIGHT   = 16'd8;
  localparam logic [31:0] FMT_GAP_LEN  = 32'd6;

  typedef struct packed {
    whp_phase_t  phase;
    logic [1:0]  group_idx;
    logic [31:0] field_shift;
    logic [15:0] held_channels;
    logic [31:0] held_rate;
    logic [15:0] held_bits;
    logic [31:0] bytes_remaining;
  } whp_state_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [1:0]  format_code;
    logic [31:0] data_length;
    logic [7:0]  audio_byte;
    logic        last;
  } whp_res_t;

  localparam whp_state_t STATE_RESET = '{
    phase:           PH_IDLE,
    group_idx:       2'd0,
    field_shift:     32'd0,
    held_channels:   16'd0,
    held_rate:       32'd0,
    held_bits:       16'd0,
    bytes_remaining: 32'd0
  };

endpackage

// ===== hdl/whp_step.sv =====
// Combinational next-state and result logic for one file byte.
// Depends on whp_pkg for the state and result records.
module whp_step (
  input  whp_pkg::whp_state_t state_i,
  input  logic [7:0]          file_byte,
  input  logic                file_start,
  output whp_pkg::whp_state_t state_o,
  output logic                res_valid,
  output whp_pkg::whp_res_t   res
);

  whp_pkg::whp_state_t cur;
  logic [31:0] shift_new;
  logic [1:0]  idx_inc;
  logic        done4;
  logic        done2;
  logic [1:0]  idx4;
  logic [1:0]  idx2;
  logic [31:0] rem_dec;
  logic        fail_en;
  logic [2:0]  fail_code;

  always_comb begin
    cur = state_i;
    if (file_start) begin
      cur = whp_pkg::STATE_RESET;
      cur.phase = whp_pkg::PH_RIFF;
    end

    shift_new = {file_byte, cur.field_shift[31:8]};
    idx_inc   = cur.group_idx + 2'd1;
    done4     = (idx_inc == 2'd0);
    done2     = (idx_inc == 2'd2);
    idx4      = done4 ? 2'd0 : idx_inc;
    idx2      = done2 ? 2'd0 : idx_inc;
    rem_dec   = cur.bytes_remaining - 32'd1;

    state_o   = cur;
    res_valid = 1'b0;
    res       = '0;
    fail_en   = 1'b0;
    fail_code = whp_pkg::ST_OK;

    case (cur.phase)
      whp_pkg::PH_RIFF: begin
        state_o.field_shift = shift_new;
        state_o.group_idx   = idx4;
        if (done4) begin
          if (shift_new != whp_pkg::SIG_RIFF) begin
            fail_en   = 1'b1;
            fail_code = whp_pkg::ST_NO_RIFF;
          end else begin
            state_o.phase = whp_pkg::PH_RSIZE;
          end
        end
      end
      whp_pkg::PH_RSIZE: begin
        state_o.field_shift = shift_new;
        state_o.group_idx   = idx4;
        if (done4) state_o.phase = whp_pkg::PH_WAVE;
      end
      whp_pkg::PH_WAVE: begin
        state_o.field_shift = shift_new;
        state_o.group_idx   = idx4;
        if (done4) begin
          if (shift_new != whp_pkg::SIG_WAVE) begin
            fail_en   = 1'b1;
            fail_code = whp_pkg::ST_NO_WAVE;
          end else begin
            state_o.phase = whp_pkg::PH_FMT;
          end
        end
      end
      whp_pkg::PH_FMT: begin
        state_o.field_shift = shift_new;
        state_o.group_idx   = idx4;
        if (done4) begin
          if (shift_new != whp_pkg::SIG_FMT) begin
            fail_en   = 1'b1;
            fail_code = whp_pkg::ST_NO_FMT;
          end else begin
            state_o.phase = whp_pkg::PH_FSIZE;
          end
        end
      end
      whp_pkg::PH_FSIZE: begin
        state_o.field_shift = shift_new;
        state_o.group_idx   = idx4;
        if (done4) state_o.phase = whp_pkg::PH_AFMT;
      end
      whp_pkg::PH_AFMT: begin
        state_o.field_shift = shift_new;
        state_o.group_idx   = idx2;
        if (done2) begin
          if (shift_new[31:16] != whp_pkg::PCM_FORMAT) begin
            fail_en   = 1'b1;
            fail_code = whp_pkg::ST_NOT_PCM;
          end else begin
            state_o.phase = whp_pkg::PH_CHAN;
          end
        end
      end
      whp_pkg::PH_CHAN: begin
        state_o.field_shift = shift_new;
        state_o.group_idx   = idx2;
        if (done2) begin
          state_o.held_channels = shift_new[31:16];
          state_o.phase         = whp_pkg::PH_RATE;
        end
      end
      whp_pkg::PH_RATE: begin
        state_o.field_shift = shift_new;
        state_o.group_idx   = idx4;
        if (done4) begin
          state_o.held_rate       = shift_new;
          state_o.bytes_remaining = whp_pkg::FMT_GAP_LEN;
          state_o.phase           = whp_pkg::PH_SKIP6;
        end
      end
      whp_pkg::PH_SKIP6: begin
        state_o.bytes_remaining = rem_dec;
        if (rem_dec == 32'd0) state_o.phase = whp_pkg::PH_BITS;
      end
      whp_pkg::PH_BITS: begin
        state_o.field_shift = shift_new;
        state_o.group_idx   = idx2;
        if (done2) begin
          state_o.held_bits = shift_new[31:16];
          state_o.phase     = whp_pkg::PH_CID;
        end
      end
      whp_pkg::PH_CID: begin
        state_o.field_shift = shift_new;
        state_o.group_idx   = idx4;
        if (done4) begin
          state_o.phase = (shift_new == whp_pkg::SIG_DATA) ? whp_pkg::PH_DSIZE
                                                           : whp_pkg::PH_CSIZE;
        end
      end
      whp_pkg::PH_CSIZE: begin
        state_o.field_shift = shift_new;
        state_o.group_idx   = idx4;
        if (done4) begin
          state_o.bytes_remaining = shift_new;
          state_o.phase = (shift_new != 32'd0) ? whp_pkg::PH_CSKIP : whp_pkg::PH_CID;
        end
      end
      whp_pkg::PH_CSKIP: begin
        state_o.bytes_remaining = rem_dec;
        if (rem_dec == 32'd0) state_o.phase = whp_pkg::PH_CID;
      end
      whp_pkg::PH_DSIZE: begin
        state_o.field_shift = shift_new;
        state_o.group_idx   = idx4;
        if (done4) begin
          if (cur.held_channels != whp_pkg::CHANS_MONO &&
              cur.held_channels != whp_pkg::CHANS_STEREO) begin
            fail_en   = 1'b1;
            fail_code = whp_pkg::ST_BAD_CHAN;
          end else begin
            res_valid             = 1'b1;
            res.status            = whp_pkg::ST_OK;
            res.channel_count     = cur.held_channels;
            res.sample_rate       = cur.held_rate;
            res.sample_bits       = cur.held_bits;
            res.format_code       = {cur.held_channels == whp_pkg::CHANS_STEREO,
                                     cur.held_bits != whp_pkg::BITS_EIGHT};
            res.data_length       = shift_new;
            res.last              = (shift_new == 32'd0);
            state_o.bytes_remaining = shift_new;
            state_o.phase = (shift_new == 32'd0) ? whp_pkg::PH_IDLE : whp_pkg::PH_DATA;
          end
        end
      end
      whp_pkg::PH_DATA: begin
        state_o.bytes_remaining = rem_dec;
        res_valid      = 1'b1;
        res.kind       = 1'b1;
        res.audio_byte = file_byte;
        res.last       = (rem_dec == 32'd0);
        if (rem_dec == 32'd0) state_o.phase = whp_pkg::PH_IDLE;
      end
      default: begin
        // Idle: bytes outside a file are dropped.
      end
    endcase

    if (fail_en) begin
      res_valid         = 1'b1;
      res               = '0;
      res.status        = fail_code;
      res.channel_count = cur.held_channels;
      res.sample_rate   = cur.held_rate;
      res.sample_bits   = cur.held_bits;
      res.last          = 1'b1;
      state_o.phase     = whp_pkg::PH_IDLE;
    end
  end

endmodule

// ===== hdl/whp_out_stage.sv =====
// Result register with valid/ready towards the receiver.
// Depends on whp_pkg for the result record.
module whp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  whp_pkg::whp_res_t res_in,
  input  logic              out_ready,
  output logic              out_valid,
  output whp_pkg::whp_res_t res_out
);

  logic              valid_r;
  logic              valid_nxt;
  whp_pkg::whp_res_t res_r;

  assign valid_nxt = load | (valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ===== hdl/wav_header_parser.sv =====
// Top level of the WAV header parser.
// Depends on whp_pkg, whp_step and whp_out_stage.
//
// The block takes a WAV file one byte per request on the in_ channel, with
// in_file_start raised on the first byte of each file. It checks the RIFF,
// WAVE and fmt signatures, demands PCM, captures channels, sample rate and
// bits per sample, skips any chunk that is not the data chunk, and then
// issues one header request followed by one request per audio byte, the
// final one flagged by out_last. A malformed file yields a single status
// request (out_last set) and the remainder of that file is dropped.
//
// Each accepted byte is first held in an input register; the parse update
// for it is then a single pass of combinational logic into the result
// register, and the request is presented on the out_ channel from there.
// One byte is taken every cycle for as long as the receiver keeps up; the
// rate is set by the combinational parse update.
// While a request waits on a stalled receiver, an empty input register still
// takes one more byte, after which in_ready stays low until out_ready rises.
// Reset clears both valid flags and returns the parser to idle, in which
// bytes are ignored until one arrives with in_file_start set.
module wav_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_file_byte,
  input  logic        in_file_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [2:0]  out_status,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_sample_rate,
  output logic [15:0] out_sample_bits,
  output logic [1:0]  out_format_code,
  output logic [31:0] out_data_length,
  output logic [7:0]  out_audio_byte,
  output logic        out_last
);

  // Input register stage.
  logic       in_valid_r;
  logic       in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_start_r;

  // Parser state.
  whp_pkg::whp_state_t state_r;
  whp_pkg::whp_state_t state_nxt;

  logic              step_res_valid;
  whp_pkg::whp_res_t step_res;
  whp_pkg::whp_res_t out_res;
  logic              stage_adv;
  logic              step_fire;
  logic              res_load;

  // The registered byte moves on whenever the result register is free or
  // is being emptied in this cycle.
  assign stage_adv = ~out_valid | out_ready;
  assign step_fire = in_valid_r & stage_adv;
  assign res_load  = step_fire & step_res_valid;
  assign in_ready  = ~in_valid_r | stage_adv;

  assign in_valid_nxt = (in_valid & in_ready) | (in_valid_r & ~stage_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid & in_ready) begin
      in_byte_r  <= in_file_byte;
      in_start_r <= in_file_start;
    end
  end

  whp_step u_step (
    .state_i    (state_r),
    .file_byte  (in_byte_r),
    .file_start (in_start_r),
    .state_o    (state_nxt),
    .res_valid  (step_res_valid),
    .res        (step_res)
  );

  // The whole state is reset so that a first file behaves exactly as after
  // a restart.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= whp_pkg::STATE_RESET;
    end else if (step_fire) begin
      state_r <= state_nxt;
    end
  end

  whp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .res_in    (step_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_status        = out_res.status;
  assign out_channel_count = out_res.channel_count;
  assign out_sample_rate   = out_res.sample_rate;
  assign out_sample_bits   = out_res.sample_bits;
  assign out_format_code   = out_res.format_code;
  assign out_data_length   = out_res.data_length;
  assign out_audio_byte    = out_res.audio_byte;
  assign out_last          = out_res.last;

  // No request is presented in the cycle after reset.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A failure status always closes the file.
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != whp_pkg::ST_OK) |-> out_last)
    else $error("error result without last marker");

  // Audio byte requests never carry a status.
  a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind) |-> (out_status == whp_pkg::ST_OK))
    else $error("audio byte with non-zero status");

  // A receiver that keeps up never back-pressures the input.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule

// ===== dv/wav_header_parser_chk.sv =====
// Checker for the WAV header parser: watches both request channels,
// predicts every result from the accepted bytes and compares them.
// Depends on whp_pkg for the phase encoding, result record and signatures.
`timescale 1ns / 100ps

module wav_header_parser_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_file_byte,
  input  logic        in_file_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_kind,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_channel_count,
  input  logic [31:0] out_sample_rate,
  input  logic [15:0] out_sample_bits,
  input  logic [1:0]  out_format_code,
  input  logic [31:0] out_data_length,
  input  logic [7:0]  out_audio_byte,
  input  logic        out_last,
  output int          mismatches,
  output int          outstanding,
  output int          headers_seen,
  output int          errors_seen,
  output int          audio_seen
);

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_AUDIO  = 1'b1;
  localparam int   PRINT_CAP   = 50;

  // Shadow copy of the parser state.
  whp_pkg::whp_phase_t phase;
  logic [1:0]  grp_idx;
  logic [31:0] shift_word;
  logic [15:0] chan_cnt;
  logic [31:0] rate_val;
  logic [15:0] bits_val;
  logic [31:0] left_cnt;

  whp_pkg::whp_res_t wav_results_q[$];

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("%0t ns chk: %s", $time, msg);
    mismatches++;
  endtask

  // Bytes enter at the top of the word, so a finished group reads little-endian.
  function automatic bit take_in(input logic [7:0] b, input int unsigned n);
    shift_word = {b, shift_word[31:8]};
    grp_idx    = grp_idx + 2'd1;
    if (grp_idx == n[1:0]) begin
      grp_idx = 2'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic end_file(input logic [2:0] status);
    whp_pkg::whp_res_t rec;
    rec               = '0;
    rec.kind          = KIND_STATUS;
    rec.status        = status;
    rec.channel_count = chan_cnt;
    rec.sample_rate   = rate_val;
    rec.sample_bits   = bits_val;
    rec.last          = 1'b1;
    wav_results_q.push_back(rec);
    phase = whp_pkg::PH_IDLE;
  endtask

  task automatic parse_file_byte(input logic [7:0] b, input logic start);
    whp_pkg::whp_res_t rec;
    rec = '0;
    if (start) begin
      phase      = whp_pkg::PH_RIFF;
      grp_idx    = '0;
      shift_word = '0;
      chan_cnt   = '0;
      rate_val   = '0;
      bits_val   = '0;
      left_cnt   = '0;
    end
    case (phase)
      whp_pkg::PH_RIFF: if (take_in(b, 4)) begin
        if (shift_word != whp_pkg::SIG_RIFF) end_file(whp_pkg::ST_NO_RIFF);
        else phase = whp_pkg::PH_RSIZE;
      end
      whp_pkg::PH_RSIZE: if (take_in(b, 4)) phase = whp_pkg::PH_WAVE;
      whp_pkg::PH_WAVE: if (take_in(b, 4)) begin
        if (shift_word != whp_pkg::SIG_WAVE) end_file(whp_pkg::ST_NO_WAVE);
        else phase = whp_pkg::PH_FMT;
      end
      whp_pkg::PH_FMT: if (take_in(b, 4)) begin
        if (shift_word != whp_pkg::SIG_FMT) end_file(whp_pkg::ST_NO_FMT);
        else phase = whp_pkg::PH_FSIZE;
      end
      whp_pkg::PH_FSIZE: if (take_in(b, 4)) phase = whp_pkg::PH_AFMT;
      whp_pkg::PH_AFMT: if (take_in(b, 2)) begin
        if (shift_word[31:16] != whp_pkg::PCM_FORMAT) end_file(whp_pkg::ST_NOT_PCM);
        else phase = whp_pkg::PH_CHAN;
      end
      whp_pkg::PH_CHAN: if (take_in(b, 2)) begin
        chan_cnt = shift_word[31:16];
        phase    = whp_pkg::PH_RATE;
      end
      whp_pkg::PH_RATE: if (take_in(b, 4)) begin
        rate_val = shift_word;
        left_cnt = whp_pkg::FMT_GAP_LEN;
        phase    = whp_pkg::PH_SKIP6;
      end
      whp_pkg::PH_SKIP6: begin
        left_cnt = left_cnt - 32'd1;
        if (left_cnt == '0) phase = whp_pkg::PH_BITS;
      end
      whp_pkg::PH_BITS: if (take_in(b, 2)) begin
        bits_val = shift_word[31:16];
        phase    = whp_pkg::PH_CID;
      end
      whp_pkg::PH_CID: if (take_in(b, 4)) begin
        if (shift_word == whp_pkg::SIG_DATA) phase = whp_pkg::PH_DSIZE;
        else phase = whp_pkg::PH_CSIZE;
      end
      whp_pkg::PH_CSIZE: if (take_in(b, 4)) begin
        left_cnt = shift_word;
        if (left_cnt != '0) phase = whp_pkg::PH_CSKIP;
        else phase = whp_pkg::PH_CID;
      end
      whp_pkg::PH_CSKIP: begin
        left_cnt = left_cnt - 32'd1;
        if (left_cnt == '0) phase = whp_pkg::PH_CID;
      end
      whp_pkg::PH_DSIZE: if (take_in(b, 4)) begin
        if (chan_cnt != whp_pkg::CHANS_MONO && chan_cnt != whp_pkg::CHANS_STEREO) begin
          end_file(whp_pkg::ST_BAD_CHAN);
        end else begin
          rec.kind          = KIND_STATUS;
          rec.status        = whp_pkg::ST_OK;
          rec.channel_count = chan_cnt;
          rec.sample_rate   = rate_val;
          rec.sample_bits   = bits_val;
          rec.format_code   = {chan_cnt == whp_pkg::CHANS_STEREO,
                               bits_val != whp_pkg::BITS_EIGHT};
          rec.data_length   = shift_word;
          rec.last          = (shift_word == '0);
          left_cnt          = shift_word;
          wav_results_q.push_back(rec);
          if (left_cnt == '0) phase = whp_pkg::PH_IDLE;
          else phase = whp_pkg::PH_DATA;
        end
      end
      whp_pkg::PH_DATA: begin
        left_cnt       = left_cnt - 32'd1;
        rec.kind       = KIND_AUDIO;
        rec.audio_byte = b;
        rec.last       = (left_cnt == '0);
        wav_results_q.push_back(rec);
        if (left_cnt == '0) phase = whp_pkg::PH_IDLE;
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] seen,
                               input logic [31:0] want);
    if (seen !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, seen, want));
  endtask

  task automatic check_result();
    whp_pkg::whp_res_t want;
    if (wav_results_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result, kind %0d status %0d",
                                out_kind, out_status));
      return;
    end
    want = wav_results_q.pop_front();
    compare_field("kind", 32'(out_kind), 32'(want.kind));
    compare_field("status", 32'(out_status), 32'(want.status));
    compare_field("channel_count", 32'(out_channel_count), 32'(want.channel_count));
    compare_field("sample_rate", out_sample_rate, want.sample_rate);
    compare_field("sample_bits", 32'(out_sample_bits), 32'(want.sample_bits));
    compare_field("format_code", 32'(out_format_code), 32'(want.format_code));
    compare_field("data_length", out_data_length, want.data_length);
    compare_field("audio_byte", 32'(out_audio_byte), 32'(want.audio_byte));
    compare_field("last", 32'(out_last), 32'(want.last));
    if (want.kind == KIND_AUDIO) audio_seen++;
    else if (want.status == whp_pkg::ST_OK) headers_seen++;
    else errors_seen++;
  endtask

  // The result side is checked before the new byte is parsed; a result passes the
  // input and result registers, so it never belongs to the byte taken at this edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      phase        = whp_pkg::PH_IDLE;
      grp_idx      = '0;
      shift_word   = '0;
      chan_cnt     = '0;
      rate_val     = '0;
      bits_val     = '0;
      left_cnt     = '0;
      mismatches   = 0;
      headers_seen = 0;
      errors_seen  = 0;
      audio_seen   = 0;
      wav_results_q.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) parse_file_byte(in_file_byte, in_file_start);
      outstanding <= wav_results_q.size();
    end
  end

endmodule

// ===== dv/wav_header_parser_tb.sv =====
// Top of the WAV header parser testbench: clock, reset, byte stimulus and
// result-side back-pressure, with the verdict. Depends on whp_pkg, the
// parser RTL and wav_header_parser_chk, which does all the checking.
`timescale 1ns / 100ps

module wav_header_parser_tb;

  // Whole-run byte budget, directed files included.
  localparam int TOTAL_BYTES  = 1100;
  // Room for the input and result registers plus the receiver's longest stall.
  localparam int END_QUIET    = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_file_byte;
  logic        in_file_start;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [2:0]  out_status;
  logic [15:0] out_channel_count;
  logic [31:0] out_sample_rate;
  logic [15:0] out_sample_bits;
  logic [1:0]  out_format_code;
  logic [31:0] out_data_length;
  logic [7:0]  out_audio_byte;
  logic        out_last;

  int mismatches;
  int outstanding;
  int headers_seen;
  int errors_seen;
  int audio_seen;

  // One file under construction: bit 8 is the file-start flag, bits 7:0 the byte.
  logic [8:0] file_bytes[$];
  // While set, both sides run flat out with no idle cycles.
  bit         calm;
  int         sent_bytes;
  int         sent_files;

  wav_header_parser uut (.*);

  wav_header_parser_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or a result never turns up.
  initial begin
    #(3_000_000);
    $display("wav_header_parser verification failed");
    $finish;
  end

  function automatic int pause_draw();
    return calm ? 0 : int'($urandom_range(0, 19));
  endfunction

  // Result side: a fresh stall is drawn before each request is taken, and
  // out_ready then stays high until a request has actually gone through.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = pause_draw();
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Presents one byte after a random gap and holds it until it is accepted.
  // Every negedge carries at most one assignment to in_valid, so a byte that
  // follows straight on keeps valid high without a glitch.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = pause_draw();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_file_byte  <= b;
    in_file_start <= start;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back({1'b0, v[8*i +: 8]});
  endtask

  // Builds a canonical PCM file image. The RIFF size, fmt size, byte rate and
  // block align are random because the parser must ignore them. Skipped
  // chunks get random ids (never the data id) and sizes up to chunk_max.
  // data_sent may differ from data_len: fewer bytes leave the file cut short,
  // more bytes give trailing bytes after the last one that must be ignored.
  task automatic make_wav(input logic [15:0] afmt, input logic [15:0] chans,
                          input logic [31:0] rate, input logic [15:0] bits,
                          input int extra, input int chunk_max,
                          input logic [31:0] data_len, input int data_sent);
    logic [31:0] id;
    logic [31:0] csize;
    file_bytes.delete();
    put_le(whp_pkg::SIG_RIFF, 4);
    put_le($urandom, 4);
    put_le(whp_pkg::SIG_WAVE, 4);
    put_le(whp_pkg::SIG_FMT, 4);
    put_le($urandom, 4);
    put_le({16'd0, afmt}, 2);
    put_le({16'd0, chans}, 2);
    put_le(rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le({16'd0, bits}, 2);
    repeat (extra) begin
      id = $urandom;
      if (id == whp_pkg::SIG_DATA) id = ~id;
      csize = $urandom_range(0, chunk_max);
      put_le(id, 4);
      put_le(csize, 4);
      repeat (csize) put_le($urandom, 1);
    end
    put_le(whp_pkg::SIG_DATA, 4);
    put_le(data_len, 4);
    repeat (data_sent) put_le($urandom, 1);
    file_bytes[0][8] = 1'b1;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i][7:0], file_bytes[i][8]);
    sent_bytes += file_bytes.size();
    sent_files++;
  endtask

  initial begin
    logic [15:0] odd_chans[3];
    logic [15:0] afmt;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] rate;
    logic [31:0] data_len;
    int          extra;
    int          data_sent;
    int          pick;
    int          idx;

    odd_chans     = '{16'd0, 16'd3, 16'hFFFF};
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_file_byte  = 8'h00;
    in_file_start = 1'b0;
    calm          = 1'b0;
    sent_bytes    = 0;
    sent_files    = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // ---- Directed part ----

    // Stray bytes with no file started yet are dropped without a result.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(whp_pkg::SIG_RIFF[7:0], 1'b0);

    // Mono 8-bit with three data bytes; the two extra bytes that follow the
    // last one belong to no file and must be ignored.
    make_wav(whp_pkg::PCM_FORMAT, whp_pkg::CHANS_MONO, 32'd8000, whp_pkg::BITS_EIGHT,
             0, 0, 32'd3, 5);
    send_file();

    // Stereo 16-bit at the top sample rate, a zero-size chunk before the data
    // chunk, and an empty data chunk, so the header request itself is last.
    make_wav(whp_pkg::PCM_FORMAT, whp_pkg::CHANS_STEREO, 32'hFFFF_FFFF, 16'd16,
             1, 0, 32'd0, 0);
    send_file();

    // Mono with an odd sample size (still reported as 16-bit) and two chunks
    // to skip ahead of the data.
    make_wav(whp_pkg::PCM_FORMAT, whp_pkg::CHANS_MONO, 32'd0, 16'hFFFF, 2, 6, 32'd2, 2);
    send_file();

    make_wav(whp_pkg::PCM_FORMAT, whp_pkg::CHANS_STEREO, 32'd44100, whp_pkg::BITS_EIGHT,
             0, 0, 32'd1, 1);
    send_file();

    // Broken signatures, each on the fourth byte of its group. A byte sent
    // after the failed file must be ignored too.
    make_wav(whp_pkg::PCM_FORMAT, whp_pkg::CHANS_MONO, 32'd8000, whp_pkg::BITS_EIGHT,
             0, 0, 32'd1, 1);
    file_bytes[3][7:0] = file_bytes[3][7:0] ^ 8'h20;
    send_file();
    send_byte(8'hA5, 1'b0);
    make_wav(whp_pkg::PCM_FORMAT, whp_pkg::CHANS_MONO, 32'd8000, whp_pkg::BITS_EIGHT,
             0, 0, 32'd1, 1);
    file_bytes[11][7:0] = file_bytes[11][7:0] ^ 8'h01;
    send_file();
    make_wav(whp_pkg::PCM_FORMAT, whp_pkg::CHANS_MONO, 32'd8000, whp_pkg::BITS_EIGHT,
             0, 0, 32'd1, 1);
    file_bytes[15][7:0] = file_bytes[15][7:0] ^ 8'h80;
    send_file();

    // Not PCM: one format code with a correct low byte, one all ones.
    make_wav(16'h0101, whp_pkg::CHANS_MONO, 32'd8000, whp_pkg::BITS_EIGHT, 0, 0, 32'd1, 1);
    send_file();
    make_wav(16'hFFFF, whp_pkg::CHANS_STEREO, 32'd8000, whp_pkg::BITS_EIGHT, 0, 0, 32'd1, 1);
    send_file();

    // Channel counts the block cannot handle, reported on the data size.
    foreach (odd_chans[i]) begin
      make_wav(whp_pkg::PCM_FORMAT, odd_chans[i], $urandom, 16'd16, 0, 0, 32'd4, 4);
      send_file();
    end

    // Largest data length; the next file restarts the parse part-way through.
    make_wav(whp_pkg::PCM_FORMAT, whp_pkg::CHANS_MONO, 32'd22050, 16'd16,
             0, 0, 32'hFFFF_FFFF, 3);
    send_file();

    // A chunk of the largest size to skip, again abandoned by a new file.
    make_wav(whp_pkg::PCM_FORMAT, whp_pkg::CHANS_STEREO, 32'd48000, 16'd16, 0, 0, 32'd0, 0);
    repeat (8) void'(file_bytes.pop_back());
    put_le(32'h5453_494C, 4);
    put_le(32'hFFFF_FFFF, 4);
    repeat (6) put_le($urandom, 1);
    send_file();

    // A file-start flag on the first byte of the audio format field restarts there.
    make_wav(whp_pkg::PCM_FORMAT, whp_pkg::CHANS_MONO, 32'd16000, whp_pkg::BITS_EIGHT,
             0, 0, 32'd2, 2);
    file_bytes[20][8] = 1'b1;
    send_file();

    make_wav(whp_pkg::PCM_FORMAT, whp_pkg::CHANS_STEREO, 32'd96000, 16'd24, 1, 3, 32'd5, 5);
    send_file();

    // ---- Random part ----
    // Mostly well-formed files with random content, so that the data phase is
    // reached often; a minority carry corrupted headers, odd field values,
    // early restarts or stray bytes between files.
    while (sent_bytes < TOTAL_BYTES) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);

      afmt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : whp_pkg::PCM_FORMAT;
      pick = $urandom_range(0, 9);
      if (pick < 4) chans = whp_pkg::CHANS_MONO;
      else if (pick < 8) chans = whp_pkg::CHANS_STEREO;
      else if (pick == 8) chans = 16'($urandom_range(0, 3));
      else chans = 16'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 4) bits = whp_pkg::BITS_EIGHT;
      else if (pick < 8) bits = 16'd16;
      else bits = 16'($urandom);
      rate  = $urandom;
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      if ($urandom_range(0, 9) == 0) begin
        data_len  = $urandom;
        data_sent = $urandom_range(0, 8);
      end else begin
        data_len  = $urandom_range(0, 16);
        data_sent = data_len;
      end
      make_wav(afmt, chans, rate, bits, extra, 6, data_len, data_sent);

      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        idx = $urandom_range(0, 35);
        file_bytes[idx][7:0] = 8'($urandom);
      end else if (pick == 2) begin
        idx = $urandom_range(1, file_bytes.size() - 1);
        file_bytes[idx][8] = 1'b1;
      end
      send_file();
    end

    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: every predicted result must come out, then a quiet spell in
    // which nothing further may appear.
    while (outstanding != 0) @(posedge clk);
    repeat (END_QUIET) @(posedge clk);

    $display("Sent %0d bytes in %0d files (stray bytes not counted).",
             sent_bytes, sent_files);
    $display("Checked %0d headers, %0d error statuses and %0d audio bytes.",
             headers_seen, errors_seen, audio_seen);
    if (mismatches == 0) begin
      $display("wav_header_parser verification clean");
    end else begin
      $display("wav_header_parser verification failed");
    end
    $finish;
  end

endmodule
